// File: hdl/swcd_pkg.sv
`timescale 1ns / 1ps

package swcd_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int POS_W = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SECTOR_BYTES - 1);

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_ONES = 32'hffffffff;
  localparam logic [31:0] FOLD_FACTOR = 32'hdeadc0de;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_PARTIAL = 1'b1;

  typedef struct packed {
    logic [31:0] window_digest;
    logic [31:0] sectors_seen;
    logic        status;
  } result_t;

  // Reflected CRC-32 update over one byte, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// File: hdl/swcd_if.sv
`timescale 1ns / 1ps

interface swcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_window;

  modport source(output valid, output data_byte, output last_of_window, input ready);
  modport sink(input valid, input data_byte, input last_of_window, output ready);
endinterface

interface swcd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] window_digest;
  logic [31:0] sectors_seen;
  logic        status;

  modport source(output valid, output window_digest, output sectors_seen, output status,
                 input ready);
  modport sink(input valid, input window_digest, input sectors_seen, input status,
               output ready);
endinterface

// File: hdl/sector_window_crc_digest_unit.sv
`timescale 1ns / 1ps

// Sector window CRC digest.
// The payload channel carries one byte per item with a flag on the final byte
// of the window. Each sector of SECTOR_BYTES bytes gets a reflected CRC-32, and
// the sector CRCs are folded into one window value. The digest channel carries
// one item per window: the digest, the number of complete sectors and a status
// that is set when the window ended in the middle of a sector.
// Throughput is one byte per cycle unless a final byte waits for a busy output
// register; the byte-wide CRC update is one unrolled XOR network between the
// input register and the result register. A final byte waits in the input
// register until the output register is free; its digest is valid from there.
// Bytes that are not final produce no item.
// Reset clears the window state and empties both registers; the block then
// accepts a byte as soon as reset is released.
// When the receiver stalls, the digest waits in the output register. Further
// bytes are still taken and processed until a second final byte reaches the
// input register, where it waits for the output register to free up.
module sector_window_crc_digest_unit (
  input logic         clk,
  input logic         rst,
  swcd_in_if.sink     payload,
  swcd_out_if.source  digest
);
  import swcd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       out_valid;
  result_t    out_data;
  result_t    core_result;
  logic       out_free;
  logic       s1_go;

  assign out_free      = !out_valid || digest.ready;
  assign s1_go         = s1_valid && (!s1_last || out_free);
  assign payload.ready = !rst && (!s1_valid || s1_go);

  swcd_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (s1_go),
    .data_byte      (s1_byte),
    .last_of_window (s1_last),
    .result         (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (payload.valid && payload.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (payload.valid && payload.ready) begin
      s1_byte <= payload.data_byte;
      s1_last <= payload.last_of_window;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      out_data <= core_result;
    end
  end

  assign digest.valid         = out_valid;
  assign digest.window_digest = out_data.window_digest;
  assign digest.sectors_seen  = out_data.sectors_seen;
  assign digest.status        = out_data.status;

endmodule

// File: hdl/swcd_core.sv
`timescale 1ns / 1ps

module swcd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             last_of_window,
  output swcd_pkg::result_t result
);
  import swcd_pkg::*;

  logic [31:0]      sector_crc;
  logic [31:0]      window_crc;
  logic [POS_W-1:0] byte_position;
  logic [31:0]      sector_counter;
  logic [31:0]      fold_sum;

  logic [31:0] crc_next;
  logic        sector_done;
  logic [31:0] window_next;
  logic [31:0] counter_next;
  logic [31:0] fold_next;

  // The fold product is kept as a running sum of the factor, one add per sector.
  always_comb begin
    crc_next     = crc_byte(sector_crc, data_byte);
    sector_done  = (byte_position == LAST_POS);
    window_next  = (crc_next ^ CRC_ONES) ^ (window_crc << 1) ^ window_crc;
    counter_next = sector_counter + 32'd1;
    fold_next    = fold_sum + FOLD_FACTOR;
  end

  always_comb begin
    if (sector_done) begin
      result.window_digest = window_next ^ fold_next;
      result.sectors_seen  = counter_next;
      result.status        = STATUS_OK;
    end else begin
      result.window_digest = 32'd0;
      result.sectors_seen  = sector_counter;
      result.status        = STATUS_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_of_window)) begin
      sector_crc     <= CRC_ONES;
      window_crc     <= CRC_ONES;
      byte_position  <= '0;
      sector_counter <= 32'd0;
      fold_sum       <= 32'd0;
    end else if (step) begin
      if (sector_done) begin
        sector_crc     <= CRC_ONES;
        window_crc     <= window_next;
        byte_position  <= '0;
        sector_counter <= counter_next;
        fold_sum       <= fold_next;
      end else begin
        sector_crc    <= crc_next;
        byte_position <= byte_position + POS_W'(1);
      end
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import swcd_pkg::*;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_t;

  typedef struct {
    logic [7:0] data;
    logic       is_end;
  } payload_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swcd_in_if  payload_if();
  swcd_out_if digest_if();

  sector_window_crc_digest_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .payload(payload_if),
    .digest (digest_if)
  );

  always #2 clk = ~clk;

  payload_byte_t byte_backlog[$];
  result_t       pending_digests[$];

  logic [31:0] run_crc = CRC_ONES;
  logic [31:0] win_fold = CRC_ONES;
  int          pos_in_sector = 0;
  logic [31:0] sector_total = '0;

  int mismatch_count = 0;
  int whole_windows = 0;
  int partial_windows = 0;
  int sectors_covered = 0;
  int bytes_taken = 0;
  int digests_checked = 0;
  int cyc = 0;
  logic holding = 1'b0;
  int hold_count = 0;

  initial begin
    payload_if.valid = 1'b0;
    payload_if.data_byte = '0;
    payload_if.last_of_window = 1'b0;
    digest_if.ready = 1'b0;
  end

  function automatic logic [31:0] crc_step8(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic is_end);
    result_t r;
    logic    sector_closed;
    sector_closed = 1'b0;
    run_crc = crc_step8(run_crc, b);
    pos_in_sector++;
    if (pos_in_sector >= SECTOR_BYTES) begin
      win_fold = (run_crc ^ CRC_ONES) ^ (win_fold << 1) ^ win_fold;
      sector_total = sector_total + 32'd1;
      run_crc = CRC_ONES;
      pos_in_sector = 0;
      sector_closed = 1'b1;
      sectors_covered++;
    end
    if (is_end) begin
      if (sector_closed) begin
        r.window_digest = win_fold ^ (FOLD_FACTOR * sector_total);
        r.status = STATUS_OK;
        whole_windows++;
      end else begin
        r.window_digest = '0;
        r.status = STATUS_PARTIAL;
        partial_windows++;
      end
      r.sectors_seen = sector_total;
      pending_digests.push_back(r);
      run_crc = CRC_ONES;
      win_fold = CRC_ONES;
      pos_in_sector = 0;
      sector_total = '0;
    end
  endtask

  task automatic add_window(input int len, input fill_kind_t fill);
    payload_byte_t p;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: p.data = 8'h00;
        FILL_ONES: p.data = 8'hff;
        default:   p.data = 8'($urandom_range(0, 255));
      endcase
      p.is_end = (i == len - 1);
      byte_backlog.push_back(p);
    end
  endtask

  function automatic logic take_a_break();
    if (cyc >= 800 && cyc < 1600) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 7;
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // The receiver stalls for a long stretch early on, while short windows are still offered.
  always @(posedge clk) begin
    if (rst) begin
      hold_count <= 0;
      holding <= 1'b0;
    end else begin
      hold_count <= hold_count + 1;
      holding <= (hold_count >= 10) && (hold_count < 330);
    end
  end

  always @(posedge clk) begin
    payload_byte_t p;
    if (rst) begin
      payload_if.valid <= 1'b0;
    end else begin
      if (payload_if.valid && payload_if.ready) begin
        absorb_byte(payload_if.data_byte, payload_if.last_of_window);
        bytes_taken++;
      end
      if (!payload_if.valid || payload_if.ready) begin
        if (byte_backlog.size() > 0 && !take_a_break()) begin
          p = byte_backlog.pop_front();
          payload_if.valid <= 1'b1;
          payload_if.data_byte <= p.data;
          payload_if.last_of_window <= p.is_end;
        end else begin
          payload_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      digest_if.ready <= 1'b0;
    end else begin
      if (digest_if.valid && digest_if.ready) begin
        if (pending_digests.size() == 0) begin
          $display("%0t: unexpected digest item: digest %h sectors %0d status %b", $time,
                   digest_if.window_digest, digest_if.sectors_seen, digest_if.status);
          mismatch_count++;
        end else begin
          want = pending_digests.pop_front();
          digests_checked++;
          if (digest_if.window_digest !== want.window_digest) begin
            $display("%0t: window_digest expected %h actual %h", $time,
                     want.window_digest, digest_if.window_digest);
            mismatch_count++;
          end
          if (digest_if.sectors_seen !== want.sectors_seen) begin
            $display("%0t: sectors_seen expected %0d actual %0d", $time,
                     want.sectors_seen, digest_if.sectors_seen);
            mismatch_count++;
          end
          if (digest_if.status !== want.status) begin
            $display("%0t: status expected %b actual %b", $time, want.status,
                     digest_if.status);
            mismatch_count++;
          end
        end
      end
      digest_if.ready <= !holding && !take_a_break();
    end
  end

  initial begin
    // Short windows first, so that they pile up behind the early receiver stall.
    add_window(1, FILL_ZERO);
    add_window(1, FILL_ONES);
    add_window(3, FILL_RANDOM);
    add_window(1, FILL_RANDOM);
    add_window(2, FILL_RANDOM);
    add_window(2 * SECTOR_BYTES, FILL_RANDOM);
    add_window(SECTOR_BYTES + 1, FILL_RANDOM);

    while (byte_backlog.size() < 1750) begin
      add_window($urandom_range(1, 6), FILL_RANDOM);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (byte_backlog.size() > 0 || payload_if.valid) @(posedge clk);
    while (pending_digests.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run took %0d payload bytes in %0d windows and checked %0d digests.",
             bytes_taken, whole_windows + partial_windows, digests_checked);
    $display("%0d windows ended on a sector boundary, %0d mid-sector, %0d sectors in all.",
             whole_windows, partial_windows, sectors_covered);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d digests still outstanding.", pending_digests.size());
    $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/swcd_pkg.sv
hdl/swcd_if.sv
hdl/swcd_core.sv
hdl/sector_window_crc_digest_unit.sv
dv/tb.sv
